// File: rtl/rlwq_pkg.sv
// ----------------------------------------------------------------------------
// rlwq_pkg
// Types and codes used by the recursive lock.
// ----------------------------------------------------------------------------
`default_nettype none

package rlwq_pkg;

	localparam logic OP_ACQUIRE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [2:0] ST_GRANTED    = 3'd0;
	localparam logic [2:0] ST_NESTED     = 3'd1;
	localparam logic [2:0] ST_QUEUED     = 3'd2;
	localparam logic [2:0] ST_FREED      = 3'd3;
	localparam logic [2:0] ST_UNNESTED   = 3'd4;
	localparam logic [2:0] ST_HANDED     = 3'd5;
	localparam logic [2:0] ST_NOT_HOLDER = 3'd6;
	localparam logic [2:0] ST_DUP_OVF    = 3'd7;

	typedef struct packed {
		logic       opcode;
		logic [3:0] thread_id;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic       woken_valid;
		logic [3:0] woken_thread;
		logic       owner_valid;
		logic [3:0] owner_thread;
		logic [7:0] nest_depth;
	} rsp_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

endpackage

`default_nettype wire

// File: rtl/reentrant_lock_with_wait_queue.sv
// ----------------------------------------------------------------------------
// reentrant_lock_with_wait_queue
// Recursive mutex with a first-in first-out queue of waiting threads.
//
// Requests arrive on the req channel (opcode, thread_id) and each one gives
// exactly one result on the rsp channel. A transfer happens at a rising edge
// where valid is high and stall is low.
// For each request, at the accepting edge the head slot of the wait queue
// memory is read; at the next edge the registered read data is used, the
// lock state and queue are updated and the result is registered.
// The single read-modify-write of the queue memory means that the block
// takes no new request while one is at work.
// A pending result holds while rsp_stall is high; req_stall stays high
// while a request is at work or a stalled result would be overwritten.
// Reset frees the lock, empties the queue and clears every waiting mark;
// queue slots themselves need no clearing as their data is used only once filled.
// ----------------------------------------------------------------------------
`default_nettype none

module reentrant_lock_with_wait_queue #(
	parameter int THREADS  = 16,
	parameter int NEST_MAX = 255
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire rlwq_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output rlwq_pkg::rsp_t     rsp
);

	import rlwq_pkg::*;

	localparam int PTR_W  = $clog2(THREADS);
	localparam int FILL_W = $clog2(THREADS + 1);
	localparam int CNT_W  = $clog2(NEST_MAX + 1);
	localparam int EXT_W  = PTR_W + 4;

	localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(THREADS - 1);
	localparam logic [PTR_W-1:0]  PTR_ONE   = PTR_W'(1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(THREADS);
	localparam logic [FILL_W-1:0] FILL_ONE  = FILL_W'(1);
	localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(NEST_MAX);
	localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);
	localparam logic [EXT_W-1:0]  ID_LIMIT  = EXT_W'(THREADS);

	state_t state_q, state_d;
	req_t   req_q;

	logic               present_q, present_d;
	logic [3:0]         id_q, id_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [PTR_W-1:0]   head_q, head_d;
	logic [PTR_W-1:0]   tail_q, tail_d;
	logic [FILL_W-1:0]  fill_q, fill_d;
	logic [THREADS-1:0] mark_q, mark_d;

	rsp_t rsp_q, rsp_d;
	logic rsp_valid_q;

	logic        accept;
	logic        mem_we;
	logic [3:0]  mem_rdata;

	logic [EXT_W-1:0]   tid_ext, next_ext;
	logic [PTR_W-1:0]   tid_idx, next_idx;
	logic               tid_ok;
	logic [CNT_W+7:0]   cnt_ext;

	assign accept    = req_valid & ~req_stall;
	assign req_stall = (state_q != S_IDLE) | (rsp_valid_q & rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	rlwq_wait_mem #(
		.DEPTH (THREADS),
		.AW    (PTR_W)
	) u_wait_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (tail_q),
		.wdata (req_q.thread_id),
		.re    (accept),
		.raddr (head_q),
		.rdata (mem_rdata)
	);

	assign tid_ext  = {{PTR_W{1'b0}}, req_q.thread_id};
	assign tid_idx  = tid_ext[PTR_W-1:0];
	assign tid_ok   = tid_ext < ID_LIMIT;
	assign next_ext = {{PTR_W{1'b0}}, mem_rdata};
	assign next_idx = next_ext[PTR_W-1:0];

	always_comb begin
		state_d   = state_q;
		present_d = present_q;
		id_d      = id_q;
		cnt_d     = cnt_q;
		head_d    = head_q;
		tail_d    = tail_q;
		fill_d    = fill_q;
		mark_d    = mark_q;
		mem_we    = 1'b0;
		rsp_d     = rsp_q;
		cnt_ext   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d            = S_IDLE;
				rsp_d.woken_valid  = 1'b0;
				rsp_d.woken_thread = 4'd0;
				priority if (!tid_ok) begin
					rsp_d.status = ST_DUP_OVF;
				end else if (req_q.opcode == OP_ACQUIRE) begin
					priority if (!present_q) begin
						present_d    = 1'b1;
						id_d         = req_q.thread_id;
						cnt_d        = CNT_ONE;
						rsp_d.status = ST_GRANTED;
					end else if (id_q == req_q.thread_id) begin
						if (cnt_q >= CNT_MAX) begin
							rsp_d.status = ST_DUP_OVF;
						end else begin
							cnt_d        = cnt_q + CNT_ONE;
							rsp_d.status = ST_NESTED;
						end
					end else if (mark_q[tid_idx] || fill_q >= FILL_FULL) begin
						rsp_d.status = ST_DUP_OVF;
					end else begin
						mem_we          = 1'b1;
						tail_d          = (tail_q == PTR_LAST) ? '0 : tail_q + PTR_ONE;
						fill_d          = fill_q + FILL_ONE;
						mark_d[tid_idx] = 1'b1;
						rsp_d.status    = ST_QUEUED;
					end
				end else begin
					priority if (!present_q || id_q != req_q.thread_id) begin
						rsp_d.status = ST_NOT_HOLDER;
					end else if (cnt_q > CNT_ONE) begin
						cnt_d        = cnt_q - CNT_ONE;
						rsp_d.status = ST_UNNESTED;
					end else if (fill_q != '0) begin
						head_d             = (head_q == PTR_LAST) ? '0 : head_q + PTR_ONE;
						fill_d             = fill_q - FILL_ONE;
						mark_d[next_idx]   = 1'b0;
						id_d               = mem_rdata;
						cnt_d              = CNT_ONE;
						rsp_d.woken_valid  = 1'b1;
						rsp_d.woken_thread = mem_rdata;
						rsp_d.status       = ST_HANDED;
					end else begin
						present_d    = 1'b0;
						id_d         = 4'd0;
						cnt_d        = '0;
						rsp_d.status = ST_FREED;
					end
				end
				cnt_ext            = {8'd0, cnt_d};
				rsp_d.owner_valid  = present_d;
				rsp_d.owner_thread = id_d;
				rsp_d.nest_depth   = cnt_ext[7:0];
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			present_q   <= 1'b0;
			id_q        <= 4'd0;
			cnt_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
			mark_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			present_q <= present_d;
			id_q      <= id_d;
			cnt_q     <= cnt_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			fill_q    <= fill_d;
			mark_q    <= mark_d;
			if (state_q == S_EXEC) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		rsp_q <= rsp_d;
	end

endmodule

`default_nettype wire

// File: rtl/rlwq_wait_mem.sv
// ----------------------------------------------------------------------------
// rlwq_wait_mem
// Ring storage for waiting thread ids: one write port, one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rlwq_wait_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [3:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [3:0]    rdata
);

	logic [3:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
